[hw/rtl/pmdd_pkg.sv]
// Shared constants and types for the polyline minimum-distance decimator.
// No dependencies; imported by every module of the block.
package pmdd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int STEP_WIDTH      = 16;
	localparam int LIM_WIDTH       = 2 * STEP_WIDTH;
	localparam int OUTQ_DEPTH      = 4;

	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

[hw/rtl/pmdd_dist.sv]
// Squared-distance test of a point against the anchor.
// Depends on pmdd_pkg for the limit width.
module pmdd_dist #(
	parameter int COORD_WIDTH = pmdd_pkg::COORD_WIDTH_DEF
) (
	input  logic [COORD_WIDTH-1:0]         x,
	input  logic [COORD_WIDTH-1:0]         y,
	input  logic [COORD_WIDTH-1:0]         anchor_x,
	input  logic [COORD_WIDTH-1:0]         anchor_y,
	input  logic [pmdd_pkg::LIM_WIDTH-1:0] lim,
	output logic                           far
);
	import pmdd_pkg::*;

	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > LIM_WIDTH) ? SUM_W : LIM_WIDTH;

	logic [COORD_WIDTH:0]   dx_raw;
	logic [COORD_WIDTH:0]   dy_raw;
	logic [COORD_WIDTH:0]   dx_abs;
	logic [COORD_WIDTH:0]   dy_abs;
	logic [SQ_W-1:0]        sx;
	logic [SQ_W-1:0]        sy;
	logic [SUM_W-1:0]       sum;

	assign dx_raw = {x[COORD_WIDTH-1], x} - {anchor_x[COORD_WIDTH-1], anchor_x};
	assign dy_raw = {y[COORD_WIDTH-1], y} - {anchor_y[COORD_WIDTH-1], anchor_y};
	assign dx_abs = dx_raw[COORD_WIDTH] ? -dx_raw : dx_raw;
	assign dy_abs = dy_raw[COORD_WIDTH] ? -dy_raw : dy_raw;

	assign sx  = SQ_W'(dx_abs[COORD_WIDTH-1:0]) * SQ_W'(dx_abs[COORD_WIDTH-1:0]);
	assign sy  = SQ_W'(dy_abs[COORD_WIDTH-1:0]) * SQ_W'(dy_abs[COORD_WIDTH-1:0]);
	assign sum = SUM_W'(sx) + SUM_W'(sy);

	assign far = CMP_W'(sum) > CMP_W'(lim);

endmodule

[hw/rtl/pmdd_outq.sv]
// Result queue: takes up to two results per cycle, drives the output stream.
// Depends on pmdd_pkg for depth and the push control struct.
module pmdd_outq #(
	parameter int DW = 2 * pmdd_pkg::COORD_WIDTH_DEF + 1
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  pmdd_pkg::push_t                            push,
	input  logic [DW-1:0]                              data_first,
	input  logic [DW-1:0]                              data_second,
	output logic [$clog2(pmdd_pkg::OUTQ_DEPTH+1)-1:0]  count,
	output logic                                       head_valid,
	input  logic                                       head_ready,
	output logic [DW-1:0]                              head_data
);
	import pmdd_pkg::*;

	localparam int PW = $clog2(OUTQ_DEPTH);
	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	logic [DW-1:0] ent_q [OUTQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [PW-1:0] wr_ptr_next;

	assign pop         = head_valid && head_ready;
	assign head_valid  = count_q != '0;
	assign head_data   = ent_q[rd_ptr_q];
	assign count       = count_q;
	assign wr_ptr_next = wr_ptr_q + PW'(1);

	always_ff @(posedge clk) begin
		if (push.first) begin
			ent_q[wr_ptr_q] <= data_first;
		end
		if (push.second) begin
			ent_q[wr_ptr_next] <= data_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.first) + PW'(push.second);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(push.first) + CW'(push.second) - CW'(pop);
		end
	end

endmodule

[hw/rtl/polyline_min_distance_decimator_core.sv]
// Top level of the polyline minimum-distance decimator.
// Depends on pmdd_pkg, pmdd_dist and pmdd_outq.
//
// channel  | direction | handshake          | payload
// s_axis   | in        | s_tvalid/s_tready  | s_tdata = {y, x}, s_tlast = final point
// m_axis   | out       | m_tvalid/m_tready  | m_tdata = {out_y, out_x}, m_tlast = line end
// cfg      | in        | cfg_we             | cfg_wdata = min_step
//
// One point per cycle while the queue has room for two results: an input register feeds
// the distance test and the decision, whose results enter a four-entry queue in the same cycle.
// A point producing two results pushes both into the queue, which sends them out one after the other.
// Input stalls only while the input register is full and the queue holds three or more.
// Reset clears line, anchor and queue state; min_step resets to zero.
module polyline_min_distance_decimator_core #(
	parameter int COORD_WIDTH = pmdd_pkg::COORD_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]            s_tdata, // point_x, point_y
	input  logic                                          s_tlast,
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]            m_tdata, // out_x, out_y
	output logic                                          m_tlast,
	input  logic                                          cfg_we,
	input  logic [pmdd_pkg::STEP_WIDTH-1:0]               cfg_wdata
);
	import pmdd_pkg::*;

	localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
	localparam int DW      = 2 * COORD_WIDTH + 1;
	localparam int CW      = $clog2(OUTQ_DEPTH + 1);

	logic                   valid_s1;
	logic [COORD_WIDTH-1:0] x_s1;
	logic [COORD_WIDTH-1:0] y_s1;
	logic                   fin_s1;

	logic [COORD_WIDTH-1:0] anchor_x_q;
	logic [COORD_WIDTH-1:0] anchor_y_q;
	logic                   line_open_q;
	logic                   held_q;
	logic [LIM_WIDTH-1:0]   lim_q;

	logic                   far;
	logic                   proc;
	logic                   accept;
	logic [CW-1:0]          q_count;
	push_t                  push;
	logic [DW-1:0]          data_first;
	logic [DW-1:0]          data_second;
	logic [DW-1:0]          head_data;

	assign proc     = valid_s1 && (q_count <= CW'(OUTQ_DEPTH - 2));
	assign s_tready = !valid_s1 || proc;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= s_tdata[COORD_WIDTH-1:0];
			y_s1   <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
			fin_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
		end else if (cfg_we) begin
			lim_q <= LIM_WIDTH'(cfg_wdata) * LIM_WIDTH'(cfg_wdata);
		end
	end

	pmdd_dist #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_dist (
		.x        (x_s1),
		.y        (y_s1),
		.anchor_x (anchor_x_q),
		.anchor_y (anchor_y_q),
		.lim      (lim_q),
		.far      (far)
	);

	always_comb begin
		push        = '0;
		data_first  = {1'b0, y_s1, x_s1};
		data_second = {1'b1, y_s1, x_s1};
		if (proc) begin
			if (!line_open_q) begin
				push.first  = 1'b1;
				push.second = fin_s1;
			end else if (!fin_s1) begin
				push.first = far && held_q;
				data_first = {1'b0, anchor_y_q, anchor_x_q};
			end else if (held_q && far) begin
				push.first  = 1'b1;
				push.second = 1'b1;
				data_first  = {1'b0, anchor_y_q, anchor_x_q};
			end else begin
				push.first = 1'b1;
				data_first = {1'b1, y_s1, x_s1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q  <= '0;
			anchor_y_q  <= '0;
			line_open_q <= 1'b0;
			held_q      <= 1'b0;
		end else if (proc) begin
			if (!line_open_q || fin_s1) begin
				anchor_x_q  <= x_s1;
				anchor_y_q  <= y_s1;
				held_q      <= 1'b0;
				line_open_q <= !fin_s1;
			end else if (far) begin
				anchor_x_q <= x_s1;
				anchor_y_q <= y_s1;
				held_q     <= 1'b1;
			end
		end
	end

	pmdd_outq #(
		.DW(DW)
	) u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.data_first  (data_first),
		.data_second (data_second),
		.count       (q_count),
		.head_valid  (m_tvalid),
		.head_ready  (m_tready),
		.head_data   (head_data)
	);

	assign m_tdata = TDATA_W'(head_data[2*COORD_WIDTH-1:0]);
	assign m_tlast = head_data[DW-1];

	a_held_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> line_open_q)
		else $error("held anchor outside an open line");

	a_fin_closes: assert property (@(posedge clk) disable iff (!arst_n)
		proc && fin_s1 |=> !line_open_q && !held_q)
		else $error("final point did not close the line");

	a_first_opens: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !fin_s1 && !line_open_q |=> line_open_q && !held_q)
		else $error("first point did not open the line");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(OUTQ_DEPTH))
		else $error("result queue overflow");

endmodule
